FILE: rtl/core/text_console_grid_cursor_macros.svh
// Assertion macros for the text console grid cursor block.
// Used by the checker; depends on nothing else.
`ifndef TEXT_CONSOLE_GRID_CURSOR_MACROS_SVH
`define TEXT_CONSOLE_GRID_CURSOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCGC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/tcgc_pkg.sv
// Shared codes, character constants and port widths of the console grid block.
// No dependencies.
`timescale 1ns / 1ps

package tcgc_pkg;

    // Request codes.
    localparam logic [1:0] REQ_PUT  = 2'd0;
    localparam logic [1:0] REQ_SET  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // Character codes with a special meaning.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BLANK = 8'h20;

    // Fixed port widths.
    localparam int REQ_W      = 2;
    localparam int WIN_PORT_W = 2;
    localparam int CHAR_W     = 8;
    localparam int COL_PORT_W = 7;
    localparam int ROW_PORT_W = 5;

endpackage

FILE: rtl/core/tcgc_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tcgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8000,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/text_console_grid_cursor.sv
// Top level of the multi-window text console engine: cursor control and grid storage.
// Depends on tcgc_pkg and tcgc_ram.
`timescale 1ns / 1ps

// Channel | Direction | Handshake              | Payload
// req     | in        | req_valid / req_ready  | req_type, window, char_code, column, row
// rsp     | out       | rsp_valid / rsp_ready  | cell_char, cursor_col, cursor_row,
//         |           |                        | scrolled, display_changed
//
// An item is accepted when the block is idle. The request is then registered, executed
// against the grid memory, and its result loaded into the output register; a read also
// waits in S_READ for the memory's registered read port. A put that scrolls then blanks
// one row, a cell at a time, through the single write port in S_BLANK.
// After reset the grid memory is swept to spaces, every cell of every window, and
// req_ready stays low until the sweep is done.
// A result waiting on rsp_ready does not hold off the next request; only a second
// finished result waits for the output register to drain.

module text_console_grid_cursor
    import tcgc_pkg::*;
#(
    parameter int GRID_COLS   = 80,
    parameter int GRID_ROWS   = 25,
    parameter int NUM_WINDOWS = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic [REQ_W-1:0]      req_type,
    input  logic [WIN_PORT_W-1:0] window,
    input  logic [CHAR_W-1:0]     char_code,
    input  logic [COL_PORT_W-1:0] column,
    input  logic [ROW_PORT_W-1:0] row,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic [CHAR_W-1:0]     cell_char,
    output logic [COL_PORT_W-1:0] cursor_col,
    output logic [ROW_PORT_W-1:0] cursor_row,
    output logic                  scrolled,
    output logic                  display_changed
);

    localparam int COL_W         = $clog2(GRID_COLS);
    localparam int ROW_W         = $clog2(GRID_ROWS);
    localparam int WIN_W         = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
    localparam int CELLS_PER_WIN = GRID_COLS * GRID_ROWS;
    localparam int DEPTH         = NUM_WINDOWS * CELLS_PER_WIN;
    localparam int ADDR_W        = $clog2(DEPTH);

    localparam logic [COL_W-1:0]      LAST_COL    = COL_W'(GRID_COLS - 1);
    localparam logic [ROW_W-1:0]      LAST_ROW    = ROW_W'(GRID_ROWS - 1);
    localparam logic [ROW_W:0]        ROWS_EXT    = (ROW_W + 1)'(GRID_ROWS);
    localparam logic [ADDR_W-1:0]     LAST_ADDR   = ADDR_W'(DEPTH - 1);
    localparam logic [COL_PORT_W-1:0] SAT_COL_IN  = COL_PORT_W'(GRID_COLS - 1);
    localparam logic [ROW_PORT_W-1:0] SAT_ROW_IN  = ROW_PORT_W'(GRID_ROWS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_BLANK,
        S_DONE
    } state_t;

    // Rows of a window are kept as a ring: logical row r sits at physical row
    // (top + r) mod GRID_ROWS, so a scroll moves the top pointer and blanks one row.
    function automatic logic [ROW_W-1:0] phys_row(
        input logic [ROW_W-1:0] top,
        input logic [ROW_W-1:0] lrow
    );
        logic [ROW_W:0] sum;
        sum = {1'b0, top} + {1'b0, lrow};
        if (sum >= ROWS_EXT)
        begin
            sum = sum - ROWS_EXT;
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [WIN_W-1:0] w,
        input logic [ROW_W-1:0] prow,
        input logic [COL_W-1:0] col
    );
        return ADDR_W'(int'(w) * CELLS_PER_WIN) + ADDR_W'(int'(prow) * GRID_COLS)
            + ADDR_W'(col);
    endfunction

    // Control and cursor state.
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [COL_W-1:0]    blank_col_reg, blank_col_next;
    logic [ROW_W-1:0]    blank_prow_reg, blank_prow_next;
    logic [COL_W-1:0]    cur_col_reg [NUM_WINDOWS];
    logic [COL_W-1:0]    cur_col_next [NUM_WINDOWS];
    logic [ROW_W-1:0]    cur_row_reg [NUM_WINDOWS];
    logic [ROW_W-1:0]    cur_row_next [NUM_WINDOWS];
    logic [ROW_W-1:0]    top_reg [NUM_WINDOWS];
    logic [ROW_W-1:0]    top_next [NUM_WINDOWS];

    // Registered request.
    logic [REQ_W-1:0]      req_type_reg, req_type_next;
    logic [WIN_PORT_W-1:0] win_reg, win_next;
    logic [CHAR_W-1:0]     char_reg, char_next;
    logic [COL_W-1:0]      rcol_reg, rcol_next;
    logic [ROW_W-1:0]      rrow_reg, rrow_next;

    // Finished result waiting for the output register.
    logic [CHAR_W-1:0] res_cell_reg, res_cell_next;
    logic [COL_W-1:0]  res_col_reg, res_col_next;
    logic [ROW_W-1:0]  res_row_reg, res_row_next;
    logic              res_scroll_reg, res_scroll_next;
    logic              res_changed_reg, res_changed_next;

    // Output register.
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [CHAR_W-1:0]     out_cell_reg, out_cell_next;
    logic [COL_PORT_W-1:0] out_col_reg, out_col_next;
    logic [ROW_PORT_W-1:0] out_row_reg, out_row_next;
    logic                  out_scroll_reg, out_scroll_next;
    logic                  out_changed_reg, out_changed_next;

    // Grid memory port signals.
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CHAR_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CHAR_W-1:0] mem_rdata;

    logic [WIN_W-1:0] win_idx;
    logic             win_ok;
    logic [COL_W-1:0] cur_c;
    logic [ROW_W-1:0] cur_r;
    logic [ROW_W-1:0] cur_top;

    assign win_idx = WIN_W'(win_reg);
    assign win_ok  = (int'(win_reg) < NUM_WINDOWS);
    assign cur_c   = cur_col_reg[win_idx];
    assign cur_r   = cur_row_reg[win_idx];
    assign cur_top = top_reg[win_idx];

    tcgc_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_grid_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        logic [COL_W-1:0] nc;
        logic [ROW_W-1:0] nr;
        logic             do_scroll;
        logic             do_write;
        logic [ROW_W-1:0] wr_lrow;
        logic [COL_W-1:0] wr_col;
        logic [CHAR_W-1:0] wr_char;

        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        blank_col_next   = blank_col_reg;
        blank_prow_next  = blank_prow_reg;
        cur_col_next     = cur_col_reg;
        cur_row_next     = cur_row_reg;
        top_next         = top_reg;
        req_type_next    = req_type_reg;
        win_next         = win_reg;
        char_next        = char_reg;
        rcol_next        = rcol_reg;
        rrow_next        = rrow_reg;
        res_cell_next    = res_cell_reg;
        res_col_next     = res_col_reg;
        res_row_next     = res_row_reg;
        res_scroll_next  = res_scroll_reg;
        res_changed_next = res_changed_reg;
        rsp_valid_next   = rsp_valid_reg;
        out_cell_next    = out_cell_reg;
        out_col_next     = out_col_reg;
        out_row_next     = out_row_reg;
        out_scroll_next  = out_scroll_reg;
        out_changed_next = out_changed_reg;

        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = CH_BLANK;
        mem_re    = 1'b0;
        mem_raddr = cell_addr(win_idx, phys_row(cur_top, rrow_reg), rcol_reg);

        nc        = cur_c;
        nr        = cur_r;
        do_scroll = 1'b0;
        do_write  = 1'b0;
        wr_lrow   = cur_r;
        wr_col    = cur_c;
        wr_char   = char_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + ADDR_W'(1);
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_type_next = req_type;
                    win_next      = window;
                    char_next     = char_code;
                    rcol_next     = (column > SAT_COL_IN) ? LAST_COL : COL_W'(column);
                    rrow_next     = (row > SAT_ROW_IN) ? LAST_ROW : ROW_W'(row);
                    state_next    = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next       = S_DONE;
                res_cell_next    = CH_NUL;
                res_scroll_next  = 1'b0;
                res_changed_next = 1'b0;
                res_col_next     = cur_c;
                res_row_next     = cur_r;
                if (!win_ok)
                begin
                    res_col_next = '0;
                    res_row_next = '0;
                end
                else
                begin
                    unique case (req_type_reg)
                        REQ_PUT:
                        begin
                            if (char_reg == CH_LF)
                            begin
                                res_changed_next = 1'b1;
                                nc = '0;
                                if (cur_r == LAST_ROW)
                                begin
                                    do_scroll = 1'b1;
                                end
                                else
                                begin
                                    nr = cur_r + ROW_W'(1);
                                end
                            end
                            else if (char_reg == CH_BS)
                            begin
                                res_changed_next = 1'b1;
                                // Backspace at the top-left cell moves no cursor and blanks no cell.
                                if (cur_c != '0 || cur_r != '0)
                                begin
                                    if (cur_c != '0)
                                    begin
                                        nc = cur_c - COL_W'(1);
                                    end
                                    else
                                    begin
                                        nc = LAST_COL;
                                        nr = cur_r - ROW_W'(1);
                                    end
                                    do_write = 1'b1;
                                    wr_lrow  = nr;
                                    wr_col   = nc;
                                    wr_char  = CH_BLANK;
                                end
                            end
                            else if (char_reg != CH_NUL)
                            begin
                                res_changed_next = 1'b1;
                                do_write = 1'b1;
                                if (cur_c == LAST_COL)
                                begin
                                    nc = '0;
                                    if (cur_r == LAST_ROW)
                                    begin
                                        do_scroll = 1'b1;
                                    end
                                    else
                                    begin
                                        nr = cur_r + ROW_W'(1);
                                    end
                                end
                                else
                                begin
                                    nc = cur_c + COL_W'(1);
                                end
                            end
                            if (do_scroll)
                            begin
                                // The old top row becomes the new last row and is blanked.
                                nr                = LAST_ROW;
                                res_scroll_next   = 1'b1;
                                blank_prow_next   = cur_top;
                                blank_col_next    = '0;
                                top_next[win_idx] = (cur_top == LAST_ROW) ? '0
                                                    : cur_top + ROW_W'(1);
                                state_next        = S_BLANK;
                            end
                            cur_col_next[win_idx] = nc;
                            cur_row_next[win_idx] = nr;
                            res_col_next          = nc;
                            res_row_next          = nr;
                        end

                        REQ_SET:
                        begin
                            cur_col_next[win_idx] = rcol_reg;
                            cur_row_next[win_idx] = rrow_reg;
                            res_col_next          = rcol_reg;
                            res_row_next          = rrow_reg;
                        end

                        REQ_READ:
                        begin
                            mem_re     = 1'b1;
                            state_next = S_READ;
                        end

                        default:
                        begin
                            // Unused request code: report the cursor, change nothing.
                        end
                    endcase
                end
                if (do_write)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cell_addr(win_idx, phys_row(cur_top, wr_lrow), wr_col);
                    mem_wdata = wr_char;
                end
            end

            S_READ:
            begin
                res_cell_next = mem_rdata;
                state_next    = S_DONE;
            end

            S_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(win_idx, blank_prow_reg, blank_col_reg);
                if (blank_col_reg == LAST_COL)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    blank_col_next = blank_col_reg + COL_W'(1);
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next   = 1'b1;
                    out_cell_next    = res_cell_reg;
                    out_col_next     = COL_PORT_W'(res_col_reg);
                    out_row_next     = ROW_PORT_W'(res_row_reg);
                    out_scroll_next  = res_scroll_reg;
                    out_changed_next = res_changed_reg;
                    state_next       = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_addr_reg    <= '0;
            blank_col_reg   <= '0;
            blank_prow_reg  <= '0;
            cur_col_reg     <= '{default: '0};
            cur_row_reg     <= '{default: '0};
            top_reg         <= '{default: '0};
            req_type_reg    <= '0;
            win_reg         <= '0;
            char_reg        <= '0;
            rcol_reg        <= '0;
            rrow_reg        <= '0;
            res_cell_reg    <= '0;
            res_col_reg     <= '0;
            res_row_reg     <= '0;
            res_scroll_reg  <= 1'b0;
            res_changed_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            out_cell_reg    <= '0;
            out_col_reg     <= '0;
            out_row_reg     <= '0;
            out_scroll_reg  <= 1'b0;
            out_changed_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            blank_col_reg   <= blank_col_next;
            blank_prow_reg  <= blank_prow_next;
            cur_col_reg     <= cur_col_next;
            cur_row_reg     <= cur_row_next;
            top_reg         <= top_next;
            req_type_reg    <= req_type_next;
            win_reg         <= win_next;
            char_reg        <= char_next;
            rcol_reg        <= rcol_next;
            rrow_reg        <= rrow_next;
            res_cell_reg    <= res_cell_next;
            res_col_reg     <= res_col_next;
            res_row_reg     <= res_row_next;
            res_scroll_reg  <= res_scroll_next;
            res_changed_reg <= res_changed_next;
            rsp_valid_reg   <= rsp_valid_next;
            out_cell_reg    <= out_cell_next;
            out_col_reg     <= out_col_next;
            out_row_reg     <= out_row_next;
            out_scroll_reg  <= out_scroll_next;
            out_changed_reg <= out_changed_next;
        end
    end

    assign req_ready       = (state_reg == S_IDLE);
    assign rsp_valid       = rsp_valid_reg;
    assign cell_char       = out_cell_reg;
    assign cursor_col      = out_col_reg;
    assign cursor_row      = out_row_reg;
    assign scrolled        = out_scroll_reg;
    assign display_changed = out_changed_reg;

endmodule

FILE: rtl/core/tcgc_checker.sv
// Port-level assertions for the console grid block, bound to its top level.
// Depends on tcgc_pkg and text_console_grid_cursor_macros.svh.
`timescale 1ns / 1ps

`include "text_console_grid_cursor_macros.svh"

module tcgc_checker
    import tcgc_pkg::*;
#(
    parameter int GRID_COLS = 80,
    parameter int GRID_ROWS = 25
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic [CHAR_W-1:0]     cell_char,
    input logic [COL_PORT_W-1:0] cursor_col,
    input logic [ROW_PORT_W-1:0] cursor_row,
    input logic                  scrolled,
    input logic                  display_changed
);

    localparam logic [COL_PORT_W-1:0] LAST_COL = COL_PORT_W'(GRID_COLS - 1);
    localparam logic [ROW_PORT_W-1:0] LAST_ROW = ROW_PORT_W'(GRID_ROWS - 1);

    // One item is worked on at a time, so ready drops right after an accept.
    `TCGC_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req_valid && req_ready, !req_ready, "ready held after accept")

    // A scroll only comes from a put and always leaves the cursor at the start of the last row.
    `TCGC_ASSERT_IMPL(a_scroll_cursor, clk, rst_n, rsp_valid && scrolled, display_changed && cursor_row == LAST_ROW && cursor_col == '0, "scroll with bad cursor")

    // The reported cursor stays inside the grid.
    `TCGC_ASSERT_IMPL(a_cursor_range, clk, rst_n, rsp_valid, cursor_col <= LAST_COL && cursor_row <= LAST_ROW, "cursor out of grid")

    // A stalled result holds its value.
    `TCGC_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(cell_char) && $stable(cursor_col) && $stable(cursor_row) && $stable(scrolled) && $stable(display_changed), "stalled result changed")

endmodule

bind text_console_grid_cursor tcgc_checker #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
) u_tcgc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .rsp_valid       (rsp_valid),
    .rsp_ready       (rsp_ready),
    .cell_char       (cell_char),
    .cursor_col      (cursor_col),
    .cursor_row      (cursor_row),
    .scrolled        (scrolled),
    .display_changed (display_changed)
);
